// File: design/wtcsh_pkg.sv
// Shared codes and constants for the width tick correction and sensor health block.
// No dependencies; the top level refers to everything here by scoped name.
package wtcsh_pkg;

  // Item command codes
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_ECHO     = 3'd1,
    CMD_LOAD_INC = 3'd2,
    CMD_LOAD_FST = 3'd3,
    CMD_LOAD_DEC = 3'd4
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_AUTO_MODE    = 2'd0,
    CFG_DELAY_SEC    = 2'd1,
    CFG_TRIG_WINDOW  = 2'd2,
    CFG_ECHO_MINIMUM = 2'd3
  } cfg_idx_e;

  // Phase codes
  typedef enum logic [1:0] {
    PHASE_UNSET    = 2'd0,
    PHASE_INTEGR   = 2'd1,
    PHASE_PROC_DLY = 2'd2
  } phase_e;

  // Pulse counter slots, also the bit order of the drive outputs
  localparam int unsigned PulseInc   = 0;
  localparam int unsigned PulseFast  = 1;
  localparam int unsigned PulseDec   = 2;
  localparam int unsigned PulseCount = 3;

  localparam int unsigned CntW    = 8;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned DelaySW = 10;
  localparam int unsigned MaskW   = 4;

  localparam logic [CntW-1:0]   CountMax       = 8'd255;
  localparam logic [PulseW-1:0] TicksPerSecond = 16'd50;

  localparam logic [DelaySW-1:0] ResetDelaySec  = 10'd10;
  localparam logic [CntW-1:0]    ResetTrigWin   = 8'd50;
  localparam logic [CntW-1:0]    ResetEchoMin   = 8'd40;

endpackage

// File: design/width_tick_correction_and_sensor_health.sv
// Width tick correction and sensor health: tick handling, echo counting, pulse counters.
// Depends on wtcsh_pkg for command codes, register indexes, phase codes and constants.
// The result beat of an accepted input beat is registered and appears on the output in the next cycle.
// Throughput: one item per cycle; the input is ready whenever the result slot is empty
//   or is being taken in the same cycle, so beats stream back to back.
// Reset (rst_ni low, asynchronous): configuration returns to its defaults (auto off,
//   10 s delay, window 50, echo minimum 40); all counters, flags, alarms, phase and
//   drive bits clear, and the output slot empties.
module width_tick_correction_and_sensor_health #(
  parameter int unsigned SENSOR_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic        paused_i,
  input  logic [1:0]  sensor_i,
  input  logic [15:0] count_value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        increase_drive_o,
  output logic        fast_increase_drive_o,
  output logic        decrease_drive_o,
  output logic [1:0]  phase_o,
  output logic        correction_active_o,
  output logic [3:0]  alarm_raise_o,
  output logic [3:0]  alarm_clear_o,
  output logic [3:0]  healthy_mask_o,
  output logic [3:0]  faulty_mask_o
);

  localparam int unsigned CntW   = wtcsh_pkg::CntW;
  localparam int unsigned PulseW = wtcsh_pkg::PulseW;
  localparam int unsigned NPulse = wtcsh_pkg::PulseCount;
  localparam int unsigned MaskW  = wtcsh_pkg::MaskW;
  // sensor numbers are compared two bits wider than the field so any sensor index up to 15 fits
  localparam int unsigned SelW   = 4;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                           auto_q;
  logic [wtcsh_pkg::DelaySW-1:0]  delay_sec_q;
  logic [CntW-1:0]                trig_win_q;
  logic [CntW-1:0]                echo_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q      <= 1'b0;
      delay_sec_q <= wtcsh_pkg::ResetDelaySec;
      trig_win_q  <= wtcsh_pkg::ResetTrigWin;
      echo_min_q  <= wtcsh_pkg::ResetEchoMin;
    end else if (cfg_we_i) begin
      unique case (wtcsh_pkg::cfg_idx_e'(cfg_idx_i))
        wtcsh_pkg::CFG_AUTO_MODE:    auto_q      <= cfg_data_i[0];
        wtcsh_pkg::CFG_DELAY_SEC:    delay_sec_q <= cfg_data_i;
        wtcsh_pkg::CFG_TRIG_WINDOW:  trig_win_q  <= cfg_data_i[CntW-1:0];
        wtcsh_pkg::CFG_ECHO_MINIMUM: echo_min_q  <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the single result slot frees as it is taken, so a new beat enters
  // in the same cycle the previous result leaves.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [SENSOR_COUNT-1:0][CntW-1:0] trig_q, trig_d;
  logic [SENSOR_COUNT-1:0][CntW-1:0] echo_q, echo_d;
  logic [SENSOR_COUNT-1:0]           healthy_q, healthy_d;
  logic [SENSOR_COUNT-1:0]           faulty_q, faulty_d;
  logic [SENSOR_COUNT-1:0]           alarm_q, alarm_d;
  logic [NPulse-1:0][PulseW-1:0]     pulse_q, pulse_d;
  logic [PulseW-1:0]                 delay_q, delay_d;
  wtcsh_pkg::phase_e                 phase_q, phase_d;
  logic [NPulse-1:0]                 drive_q, drive_d;
  logic [SENSOR_COUNT-1:0]           raise_d, clear_d;
  logic [SENSOR_COUNT-1:0]           raise_q, clear_q;

  // delay load is seconds times fifty; a constant product, fits 16 bits for any 10-bit value
  logic [PulseW-1:0] delay_load;
  assign delay_load = PulseW'(delay_sec_q) * wtcsh_pkg::TicksPerSecond;

  logic [SelW-1:0] sel;
  assign sel = SelW'(sensor_i);

  always_comb begin
    logic expired;
    logic [PulseW-1:0] dly_next;

    trig_d    = trig_q;
    echo_d    = echo_q;
    healthy_d = healthy_q;
    faulty_d  = faulty_q;
    alarm_d   = alarm_q;
    pulse_d   = pulse_q;
    delay_d   = delay_q;
    phase_d   = phase_q;
    drive_d   = drive_q;
    raise_d   = '0;
    clear_d   = '0;
    expired   = 1'b0;
    dly_next  = delay_q;

    unique case (wtcsh_pkg::cmd_e'(command_i))
      wtcsh_pkg::CMD_TICK: begin
        if (!paused_i) begin
          for (int i = 0; i < SENSOR_COUNT; i++) begin
            // judge a sensor whose window is full, then clear its counts
            if (trig_q[i] >= trig_win_q) begin
              trig_d[i]    = '0;
              echo_d[i]    = '0;
              healthy_d[i] = echo_q[i] > echo_min_q;
              faulty_d[i]  = !(echo_q[i] > echo_min_q);
            end
            // raise or clear the alarm only on a change
            if (faulty_d[i] && !alarm_q[i]) begin
              alarm_d[i] = 1'b1;
              raise_d[i] = 1'b1;
            end else if (healthy_d[i] && alarm_q[i]) begin
              alarm_d[i] = 1'b0;
              clear_d[i] = 1'b1;
            end
            // bump the triggered sensor after judging, saturating
            if (sel == SelW'(i) && trig_d[i] != wtcsh_pkg::CountMax) begin
              trig_d[i] = trig_d[i] + CntW'(1);
            end
          end
        end
        // drive and decrement each pulse counter on every tick
        for (int p = 0; p < NPulse; p++) begin
          drive_d[p] = pulse_q[p] != '0;
          if (pulse_q[p] != '0) begin
            pulse_d[p] = pulse_q[p] - PulseW'(1);
            if (pulse_q[p] == PulseW'(1) && auto_q) begin
              expired = 1'b1;
            end
          end
        end
        if (delay_q != '0) begin
          dly_next = delay_q - PulseW'(1);
          if (delay_q == PulseW'(1) && auto_q) begin
            phase_d = wtcsh_pkg::PHASE_INTEGR;
          end
        end
        delay_d = dly_next;
        // a pulse expiry outranks the delay running out on the same tick
        if (expired) begin
          phase_d = wtcsh_pkg::PHASE_PROC_DLY;
          delay_d = delay_load;
        end
      end
      wtcsh_pkg::CMD_ECHO: begin
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          if (sel == SelW'(i) && echo_q[i] != wtcsh_pkg::CountMax) begin
            echo_d[i] = echo_q[i] + CntW'(1);
          end
        end
      end
      wtcsh_pkg::CMD_LOAD_INC: pulse_d[wtcsh_pkg::PulseInc]  = count_value_i;
      wtcsh_pkg::CMD_LOAD_FST: pulse_d[wtcsh_pkg::PulseFast] = count_value_i;
      wtcsh_pkg::CMD_LOAD_DEC: pulse_d[wtcsh_pkg::PulseDec]  = count_value_i;
      default: ; // unknown commands leave the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q      <= '0;
      echo_q      <= '0;
      healthy_q   <= '0;
      faulty_q    <= '0;
      alarm_q     <= '0;
      pulse_q     <= '0;
      delay_q     <= '0;
      phase_q     <= wtcsh_pkg::PHASE_UNSET;
      drive_q     <= '0;
      raise_q     <= '0;
      clear_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        trig_q    <= trig_d;
        echo_q    <= echo_d;
        healthy_q <= healthy_d;
        faulty_q  <= faulty_d;
        alarm_q   <= alarm_d;
        pulse_q   <= pulse_d;
        delay_q   <= delay_d;
        phase_q   <= phase_d;
        drive_q   <= drive_d;
        raise_q   <= raise_d;
        clear_q   <= clear_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat. State only moves when a beat is accepted, and a beat is only
  // accepted when the slot frees, so the state registers always hold the state
  // after the item now on the output; only the per-item alarm edges need their
  // own registers. The user changes configuration only while idle; not enforced.
  // ---------------------------------------------------------------------------
  assign out_valid_o           = out_valid_q;
  assign increase_drive_o      = drive_q[wtcsh_pkg::PulseInc];
  assign fast_increase_drive_o = drive_q[wtcsh_pkg::PulseFast];
  assign decrease_drive_o      = drive_q[wtcsh_pkg::PulseDec];
  assign phase_o               = phase_q;
  assign correction_active_o   = auto_q && (pulse_q != '0);

  // masks carry sensors 0 to 3; missing sensors read as zero
  for (genvar j = 0; j < MaskW; j++) begin : g_mask
    if (j < SENSOR_COUNT) begin : g_have
      assign alarm_raise_o[j]  = raise_q[j];
      assign alarm_clear_o[j]  = clear_q[j];
      assign healthy_mask_o[j] = healthy_q[j];
      assign faulty_mask_o[j]  = faulty_q[j];
    end else begin : g_none
      assign alarm_raise_o[j]  = 1'b0;
      assign alarm_clear_o[j]  = 1'b0;
      assign healthy_mask_o[j] = 1'b0;
      assign faulty_mask_o[j]  = 1'b0;
    end
  end

`ifndef SYNTHESIS
  // a sensor is never judged healthy and faulty at once
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (healthy_q & faulty_q) == '0)
    else $error("sensor flagged healthy and faulty together");

  // an alarm cannot be raised and cleared on the same item
  a_raise_clear_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (raise_q & clear_q) == '0)
    else $error("alarm raised and cleared on one item");

  // every accepted beat lands in the result slot
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");

  // only an unpaused tick may move the alarms
  a_alarm_only_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (command_i != wtcsh_pkg::CMD_TICK || paused_i)
      |=> raise_q == '0 && clear_q == '0 && $stable(alarm_q))
    else $error("alarm changed outside an unpaused tick");
`endif

endmodule
